/* hdl/mracc_pkg.sv */
// shared types, constants and lane widths of the multiply-add round cipher
// no dependencies; imported by every module of the block
package mracc_pkg;

	localparam int unsigned LANE_W = 16;
	localparam int unsigned LANES = 8;
	localparam int unsigned BLOCK_W = LANE_W * LANES;
	localparam int unsigned ROUND_COUNT_DEF = 8;

	// layer multipliers and their inverses mod 2^16
	localparam logic [LANE_W-1:0] MUL_FIRST = 16'd62743;
	localparam logic [LANE_W-1:0] INV_FIRST = 16'd37543;
	localparam logic [LANE_W-1:0] MUL_MIDDLE = 16'd63127;
	localparam logic [LANE_W-1:0] INV_MIDDLE = 16'd59687;
	localparam logic [LANE_W-1:0] MUL_LAST = 16'd58537;
	localparam logic [LANE_W-1:0] INV_LAST = 16'd65433;

	// configuration register indexes
	localparam int unsigned CFG_INDEX_W = 2;
	localparam logic [CFG_INDEX_W-1:0] REG_KEY_FIRST = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_KEY_MIDDLE = 2'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_KEY_LAST = 2'd2;

	typedef enum logic {
		CMD_ENCRYPT = 1'b0,
		CMD_DECRYPT = 1'b1
	} cmd_t;

	typedef struct packed {
		logic [LANE_W-1:0] first;
		logic [LANE_W-1:0] middle;
		logic [LANE_W-1:0] last;
	} key_set_t;

	typedef logic [LANES-1:0][LANE_W-1:0] block_t;

endpackage

/* hdl/mracc_cell.sv */
// one layer of the cipher for all eight lanes, with its own stage register
// depends on mracc_pkg
module mracc_cell
	import mracc_pkg::*;
#(
	parameter int unsigned STAGE = 0,
	parameter int unsigned ROUND_COUNT = ROUND_COUNT_DEF
) (
	input  logic     clk,
	input  logic     arst_n,
	input  key_set_t keys,
	input  logic     in_valid,
	output logic     in_ready,
	input  cmd_t     in_cmd,
	input  block_t   in_data,
	output logic     out_valid,
	input  logic     out_ready,
	output cmd_t     out_cmd,
	output block_t   out_data
);

	// encryption: this cell is layer STAGE+1; decryption walks the layers backward
	localparam bit ENC_FIRST = (STAGE == 0);
	localparam bit ENC_LAST = (STAGE == ROUND_COUNT - 1);
	localparam int unsigned ENC_ROUND = STAGE + 1;
	localparam int unsigned DEC_ROUND = ROUND_COUNT - STAGE;
	localparam bit DEC_LAST_INV = (STAGE == 0);
	localparam bit DEC_FIRST_INV = (STAGE == ROUND_COUNT - 1);

	localparam logic [LANE_W-1:0] ENC_MUL =
		ENC_FIRST ? MUL_FIRST : (ENC_LAST ? MUL_LAST : MUL_MIDDLE);
	localparam logic [LANE_W-1:0] DEC_MUL =
		DEC_LAST_INV ? INV_LAST : (DEC_FIRST_INV ? INV_FIRST : INV_MIDDLE);
	localparam logic [LANE_W-1:0] ENC_XOR = ENC_LAST ? '0 : LANE_W'(ENC_ROUND % 256);
	localparam logic [LANE_W-1:0] DEC_XOR = DEC_LAST_INV ? '0 : LANE_W'(DEC_ROUND % 256);

	logic [LANE_W-1:0] enc_key;
	logic [LANE_W-1:0] dec_key;
	block_t            next_data;
	logic              valid_q;
	cmd_t              cmd_q;
	block_t            data_q;

	always_comb begin
		if (ENC_FIRST) begin
			enc_key = keys.first;
		end else if (ENC_LAST) begin
			enc_key = keys.last;
		end else begin
			enc_key = keys.middle;
		end
		if (DEC_LAST_INV) begin
			dec_key = keys.last;
		end else if (DEC_FIRST_INV) begin
			dec_key = keys.first;
		end else begin
			dec_key = keys.middle;
		end
	end

	// one shared 16x16 multiplier per lane, operands picked by direction
	for (genvar j = 0; j < LANES; j++) begin : g_lane
		logic [LANE_W-1:0]   mul_a;
		logic [LANE_W-1:0]   mul_b;
		logic [2*LANE_W-1:0] prod;
		logic [LANE_W-1:0]   enc_sum;

		always_comb begin
			if (in_cmd == CMD_DECRYPT) begin
				mul_a = (in_data[j] ^ DEC_XOR) - dec_key;
				mul_b = DEC_MUL;
			end else begin
				mul_a = in_data[j];
				mul_b = ENC_MUL;
			end
			prod = mul_a * mul_b;
			enc_sum = (enc_key + prod[LANE_W-1:0]) ^ ENC_XOR;
			next_data[j] = (in_cmd == CMD_DECRYPT) ? prod[LANE_W-1:0] : enc_sum;
		end
	end

	assign in_ready = !valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_ready) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			cmd_q <= in_cmd;
			data_q <= next_data;
		end
	end

	assign out_valid = valid_q;
	assign out_cmd = cmd_q;
	assign out_data = data_q;

endmodule

/* hdl/multiply_add_round_cipher_core.sv */
// top level of the multiply-add round cipher: stream ports, key registers, chain of layer cells
// depends on mracc_pkg and mracc_cell
//
// The block encrypts or decrypts a 128-bit block held as eight independent 16-bit lanes
// (word_0 in the lowest bits of s_tdata) under three 16-bit key words written through the
// cfg port (index 0 key_first, 1 key_middle, 2 key_last; other indexes are ignored).
// s_tuser carries the direction: 0 encrypt, 1 decrypt. Each of the ROUND_COUNT layers is
// one registered cell doing a single 16x16 multiply per lane, so a new item is taken every
// cycle when the output side does not stall, and its result passes through the cells in
// layer order to m_tdata; each cell holds its own item and stalls only when its successor
// is full, so bubbles close up. Keys must be written only while no item is in flight.
module multiply_add_round_cipher_core
	import mracc_pkg::*;
#(
	parameter int unsigned ROUND_COUNT = ROUND_COUNT_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	// input items
	input  logic                   s_tvalid,
	output logic                   s_tready,
	input  logic [BLOCK_W-1:0]     s_tdata,   // word_0 .. word_7, 16 bits each, word_0 lowest
	input  logic [0:0]             s_tuser,   // cmd
	// result items
	output logic                   m_tvalid,
	input  logic                   m_tready,
	output logic [BLOCK_W-1:0]     m_tdata,   // result_0 .. result_7, 16 bits each, result_0 lowest
	// key register writes
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [LANE_W-1:0]      cfg_data
);

	key_set_t keys_q;

	// chain links: index 0 is the input side, index ROUND_COUNT the output side
	logic   valid_c [ROUND_COUNT+1];
	logic   ready_c [ROUND_COUNT+1];
	cmd_t   cmd_c   [ROUND_COUNT+1];
	block_t data_c  [ROUND_COUNT+1];

	// key registers, always ready
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			keys_q <= '0;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_KEY_FIRST:  keys_q.first <= cfg_data;
				REG_KEY_MIDDLE: keys_q.middle <= cfg_data;
				REG_KEY_LAST:   keys_q.last <= cfg_data;
				default:        keys_q <= keys_q;
			endcase
		end
	end

	// input side of the chain
	assign valid_c[0] = s_tvalid;
	assign s_tready = ready_c[0];
	assign cmd_c[0] = cmd_t'(s_tuser[0]);
	assign data_c[0] = block_t'(s_tdata);

	// one cell per layer
	for (genvar i = 0; i < ROUND_COUNT; i++) begin : g_cell
		mracc_cell #(
			.STAGE      (i),
			.ROUND_COUNT(ROUND_COUNT)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.keys     (keys_q),
			.in_valid (valid_c[i]),
			.in_ready (ready_c[i]),
			.in_cmd   (cmd_c[i]),
			.in_data  (data_c[i]),
			.out_valid(valid_c[i+1]),
			.out_ready(ready_c[i+1]),
			.out_cmd  (cmd_c[i+1]),
			.out_data (data_c[i+1])
		);
	end

	// output side: last cell register drives the result item directly
	assign m_tvalid = valid_c[ROUND_COUNT];
	assign ready_c[ROUND_COUNT] = m_tready;
	assign m_tdata = BLOCK_W'(data_c[ROUND_COUNT]);

endmodule
